// File: rtl/core/vmmc_pkg.sv
// Package for the vehicle mission mode controller.
// Holds the mode codes, the event list, the flag bundle and the transition lookup.
// No dependencies; imported by vmmc_chain, the core top, vmmc_mode_checker and the tb.
package vmmc_pkg;

  localparam int ModeW = 4;

  typedef logic [ModeW-1:0] mode_t;

  // Mission mode codes, in order of declaration
  localparam mode_t MODE_STAY    = 4'd0;
  localparam mode_t MODE_DOWN    = 4'd1;
  localparam mode_t MODE_EXPLORE = 4'd2;
  localparam mode_t MODE_OBJ1    = 4'd3;
  localparam mode_t MODE_OBJ2    = 4'd4;
  localparam mode_t MODE_PIPE1   = 4'd5;
  localparam mode_t MODE_PIPE2   = 4'd6;
  localparam mode_t MODE_WALL    = 4'd7;
  localparam mode_t MODE_UP      = 4'd8;
  localparam mode_t MODE_REMOTE  = 4'd9;

  typedef enum logic [3:0] {
    EV_AUTONOMOUS,
    EV_DOWN,
    EV_EXPLORE,
    EV_FOUND1,
    EV_FOUND2,
    EV_PIPE1,
    EV_PIPE2,
    EV_LOSE_TARGET,
    EV_UP,
    EV_REMOTE
  } event_t;

  // Command and detection flags of one transaction
  typedef struct packed {
    logic remote_request;
    logic unlocked;
    logic stabilize_cmd;
    logic descend_cmd;
    logic ascend_cmd;
    logic explore_cmd;
    logic nofollow_cmd;
    logic obj_cam1;
    logic obj_cam2;
    logic pipe_cam1;
    logic pipe_cam2;
    logic obstacle_detect;
  } flags_t;

  // True for the follow modes that a lost target leaves (object, pipe, wall)
  function automatic logic is_follow(input mode_t m);
    return (m >= MODE_OBJ1) && (m <= MODE_WALL);
  endfunction

  // Apply one event: move only on a table hit with the guard open
  function automatic mode_t fire(input mode_t m, input event_t ev, input logic unlocked);
    logic  hit;
    mode_t nxt;
    hit = 1'b0;
    nxt = m;
    unique case (ev)
      EV_AUTONOMOUS: begin
        if (m == MODE_REMOTE || m == MODE_DOWN || m == MODE_UP || m == MODE_EXPLORE) begin
          hit = 1'b1;
          nxt = MODE_STAY;
        end
      end
      EV_DOWN: begin
        if (m == MODE_STAY) begin
          hit = 1'b1;
          nxt = MODE_DOWN;
        end
      end
      EV_UP: begin
        if (m == MODE_STAY) begin
          hit = 1'b1;
          nxt = MODE_UP;
        end
      end
      EV_EXPLORE: begin
        if (m == MODE_STAY) begin
          hit = 1'b1;
          nxt = MODE_EXPLORE;
        end
      end
      EV_FOUND1: begin
        if (m == MODE_EXPLORE) begin
          hit = 1'b1;
          nxt = MODE_OBJ1;
        end
      end
      EV_FOUND2: begin
        if (m == MODE_EXPLORE) begin
          hit = 1'b1;
          nxt = MODE_OBJ2;
        end
      end
      EV_PIPE1: begin
        if (m == MODE_EXPLORE || m == MODE_OBJ1) begin
          hit = 1'b1;
          nxt = MODE_PIPE1;
        end
      end
      EV_PIPE2: begin
        if (m == MODE_EXPLORE || m == MODE_OBJ2) begin
          hit = 1'b1;
          nxt = MODE_PIPE2;
        end
      end
      EV_LOSE_TARGET: begin
        if (is_follow(m)) begin
          hit = 1'b1;
          nxt = MODE_EXPLORE;
        end
      end
      EV_REMOTE: begin
        if (is_follow(m)) begin
          hit = 1'b1;
          nxt = MODE_EXPLORE;
        end else if (m == MODE_EXPLORE || m == MODE_DOWN || m == MODE_UP) begin
          hit = 1'b1;
          nxt = MODE_STAY;
        end else if (m == MODE_STAY) begin
          hit = 1'b1;
          nxt = MODE_REMOTE;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    return (hit && unlocked) ? nxt : m;
  endfunction

endpackage

// File: rtl/core/vmmc_chain.sv
// Event chain of the mission mode controller: one tick of ordered events.
// Pure combinational; depends on vmmc_pkg for mode codes and the lookup.
module vmmc_chain
  import vmmc_pkg::*;
(
  input  mode_t  mode_cur,
  input  flags_t flags,
  output mode_t  mode_next
);

  always_comb begin
    mode_t  m;
    logic   g;
    flags_t f;
    f = flags;
    g = f.unlocked;
    m = mode_cur;

    // Retreat on obstacle, chosen by the mode at the start of the tick
    if (f.obstacle_detect) begin
      if (m == MODE_EXPLORE) begin
        m = fire(m, EV_AUTONOMOUS, g);
      end else if (m == MODE_STAY) begin
        m = fire(m, EV_UP, g);
      end else if (m >= MODE_OBJ1 && m <= MODE_PIPE2) begin
        m = fire(m, EV_LOSE_TARGET, g);
      end
    end

    // Operator remote request and return to autonomy
    if (m != MODE_REMOTE && f.remote_request) m = fire(m, EV_REMOTE, g);
    if ((m == MODE_REMOTE && !f.remote_request) || f.stabilize_cmd) begin
      m = fire(m, EV_AUTONOMOUS, g);
    end

    // Direct commands
    if (f.descend_cmd)  m = fire(m, EV_DOWN, g);
    if (f.ascend_cmd)   m = fire(m, EV_UP, g);
    if (f.explore_cmd)  m = fire(m, EV_EXPLORE, g);
    if (f.nofollow_cmd) m = fire(m, EV_LOSE_TARGET, g);

    // Explore: climb, or lock onto a pipe or an object
    if (m == MODE_EXPLORE) begin
      if (f.ascend_cmd) m = fire(m, EV_UP, g);
      if (!f.nofollow_cmd && !f.obstacle_detect) begin
        if (f.pipe_cam1) m = fire(m, EV_PIPE1, g);
        if (f.pipe_cam2) m = fire(m, EV_PIPE2, g);
        if (f.obj_cam1)  m = fire(m, EV_FOUND1, g);
        if (f.obj_cam2)  m = fire(m, EV_FOUND2, g);
      end
    end

    // Follow object: hand over to pipe, or drop when target is lost
    if (m == MODE_OBJ1) begin
      if (f.pipe_cam1) m = fire(m, EV_PIPE1, g);
      if (!f.obj_cam1 && !f.pipe_cam1) m = fire(m, EV_LOSE_TARGET, g);
    end
    if (m == MODE_OBJ2) begin
      if (f.pipe_cam2) m = fire(m, EV_PIPE2, g);
      if (!f.obj_cam2 && !f.pipe_cam2) m = fire(m, EV_LOSE_TARGET, g);
    end

    // Follow pipe: drop when the pipe is lost
    if (m == MODE_PIPE1 && !f.pipe_cam1) m = fire(m, EV_LOSE_TARGET, g);
    if (m == MODE_PIPE2 && !f.pipe_cam2) m = fire(m, EV_LOSE_TARGET, g);

    mode_next = m;
  end

endmodule

// File: rtl/core/vehicle_mission_mode_controller_core.sv
// Top level of the vehicle mission mode controller.
// Depends on vmmc_pkg and vmmc_chain.
//
// Usage:
//   Input channel: in_valid / in_stall with one port per flag. A transaction
//   is taken at a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with the 4-bit mode port. The
//   result is taken at a rising edge with out_valid high and out_stall low.
//   Each input transaction yields exactly one result, the mission mode after
//   the tick's ordered event chain has been applied.
//   The result is registered and appears the cycle after acceptance.
//   Throughput: 1 transaction per cycle unless out_stall holds a result.
//   The event chain is combinational on the mode register, which is also
//   the result register, so the next transaction sees the new mode at once.
//   Stall: while a result is held under out_stall, in_stall is raised and
//   the mode and result stay frozen; a result being taken in the same cycle
//   frees the slot for a new transaction.
//   Reset: mode returns to remote control (9) and out_valid clears.
module vehicle_mission_mode_controller_core
  import vmmc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  remote_request,
  input  logic  unlocked,
  input  logic  stabilize_cmd,
  input  logic  descend_cmd,
  input  logic  ascend_cmd,
  input  logic  explore_cmd,
  input  logic  nofollow_cmd,
  input  logic  obj_cam1,
  input  logic  obj_cam2,
  input  logic  pipe_cam1,
  input  logic  pipe_cam2,
  input  logic  obstacle_detect,
  output logic  out_valid,
  input  logic  out_stall,
  output mode_t mode
);

  flags_t flags;
  mode_t  mission_mode;
  mode_t  mission_mode_next;
  logic   in_fire;

  // Bundle the flags of the incoming transaction
  assign flags = '{
    remote_request:  remote_request,
    unlocked:        unlocked,
    stabilize_cmd:   stabilize_cmd,
    descend_cmd:     descend_cmd,
    ascend_cmd:      ascend_cmd,
    explore_cmd:     explore_cmd,
    nofollow_cmd:    nofollow_cmd,
    obj_cam1:        obj_cam1,
    obj_cam2:        obj_cam2,
    pipe_cam1:       pipe_cam1,
    pipe_cam2:       pipe_cam2,
    obstacle_detect: obstacle_detect
  };

  vmmc_chain u_chain (
    .mode_cur  (mission_mode),
    .flags     (flags),
    .mode_next (mission_mode_next)
  );

  // Hold off input only while a result waits under stall
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // Advance the mode on each accepted transaction; it is also the result
  always_ff @(posedge clk) begin
    if (rst) begin
      mission_mode <= MODE_REMOTE;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        mission_mode <= mission_mode_next;
      end
      out_valid <= in_fire || (out_valid && out_stall);
    end
  end

  assign mode = mission_mode;

  // Mode stays within the defined codes and never enters wall follow
  assert property (@(posedge clk) disable iff (rst)
    (mission_mode <= MODE_REMOTE) && (mission_mode != MODE_WALL))
    else $error("mission mode left its reachable set");

  // A transaction taken always produces a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted transaction produced no result");

  // With the guard closed, the mode does not move
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && !unlocked) |=> $stable(mission_mode))
    else $error("mode moved while locked");

  // A held result is not overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(mission_mode) && out_valid)
    else $error("stalled result changed");

endmodule

// File: dv/vmmc_mode_checker.sv
// Checker for the vehicle mission mode controller: tracks the mission mode per
// accepted flag transaction and compares every result transaction against it.
// Depends on vmmc_pkg for the mode codes, the event list and the flag bundle.
module vmmc_mode_checker
  import vmmc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  logic   in_stall,
  input  flags_t flags,
  input  logic   out_valid,
  input  logic   out_stall,
  input  mode_t  mode,
  output int     mismatch_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  mode_t tracked_mode;
  mode_t expected_modes[$];
  mode_t want;

  initial begin
    mismatch_count = 0;
    pending = 0;
    tracked_mode = MODE_REMOTE;
  end

  // Next mode for one event; a miss in the table or a closed guard keeps the mode
  function automatic mode_t apply_event(input mode_t m, input event_t ev, input logic open);
    mode_t nxt;
    nxt = m;
    case (ev)
      EV_AUTONOMOUS: begin
        if (m == MODE_REMOTE || m == MODE_DOWN || m == MODE_UP || m == MODE_EXPLORE) begin
          nxt = MODE_STAY;
        end
      end
      EV_DOWN:     if (m == MODE_STAY) nxt = MODE_DOWN;
      EV_UP:       if (m == MODE_STAY) nxt = MODE_UP;
      EV_EXPLORE:  if (m == MODE_STAY) nxt = MODE_EXPLORE;
      EV_FOUND1:   if (m == MODE_EXPLORE) nxt = MODE_OBJ1;
      EV_FOUND2:   if (m == MODE_EXPLORE) nxt = MODE_OBJ2;
      EV_PIPE1:    if (m == MODE_EXPLORE || m == MODE_OBJ1) nxt = MODE_PIPE1;
      EV_PIPE2:    if (m == MODE_EXPLORE || m == MODE_OBJ2) nxt = MODE_PIPE2;
      EV_LOSE_TARGET: begin
        if (m >= MODE_OBJ1 && m <= MODE_WALL) nxt = MODE_EXPLORE;
      end
      EV_REMOTE: begin
        if (m >= MODE_OBJ1 && m <= MODE_WALL) begin
          nxt = MODE_EXPLORE;
        end else if (m == MODE_EXPLORE || m == MODE_DOWN || m == MODE_UP) begin
          nxt = MODE_STAY;
        end else if (m == MODE_STAY) begin
          nxt = MODE_REMOTE;
        end
      end
      default: nxt = m;
    endcase
    return open ? nxt : m;
  endfunction

  // Run the ordered event chain of one tick, each event seeing the updated mode
  function automatic mode_t tick_mode(input mode_t start, input flags_t f);
    mode_t m;
    logic  g;
    m = start;
    g = f.unlocked;
    // obstacle forces a retreat chosen by the mode at tick start
    if (f.obstacle_detect) begin
      if (m == MODE_EXPLORE) begin
        m = apply_event(m, EV_AUTONOMOUS, g);
      end else if (m == MODE_STAY) begin
        m = apply_event(m, EV_UP, g);
      end else if (m >= MODE_OBJ1 && m <= MODE_PIPE2) begin
        m = apply_event(m, EV_LOSE_TARGET, g);
      end
    end
    if (m != MODE_REMOTE && f.remote_request) m = apply_event(m, EV_REMOTE, g);
    if ((m == MODE_REMOTE && !f.remote_request) || f.stabilize_cmd) begin
      m = apply_event(m, EV_AUTONOMOUS, g);
    end
    // operator commands
    if (f.descend_cmd) m = apply_event(m, EV_DOWN, g);
    if (f.ascend_cmd) m = apply_event(m, EV_UP, g);
    if (f.explore_cmd) m = apply_event(m, EV_EXPLORE, g);
    if (f.nofollow_cmd) m = apply_event(m, EV_LOSE_TARGET, g);
    // exploring: climb, or lock onto whatever the cameras report
    if (m == MODE_EXPLORE) begin
      if (f.ascend_cmd) m = apply_event(m, EV_UP, g);
      if (!f.nofollow_cmd && !f.obstacle_detect) begin
        if (f.pipe_cam1) m = apply_event(m, EV_PIPE1, g);
        if (f.pipe_cam2) m = apply_event(m, EV_PIPE2, g);
        if (f.obj_cam1) m = apply_event(m, EV_FOUND1, g);
        if (f.obj_cam2) m = apply_event(m, EV_FOUND2, g);
      end
    end
    // following: hand over to a pipe, or drop a lost target
    if (m == MODE_OBJ1) begin
      if (f.pipe_cam1) m = apply_event(m, EV_PIPE1, g);
      if (!f.obj_cam1 && !f.pipe_cam1) m = apply_event(m, EV_LOSE_TARGET, g);
    end
    if (m == MODE_OBJ2) begin
      if (f.pipe_cam2) m = apply_event(m, EV_PIPE2, g);
      if (!f.obj_cam2 && !f.pipe_cam2) m = apply_event(m, EV_LOSE_TARGET, g);
    end
    if (m == MODE_PIPE1 && !f.pipe_cam1) m = apply_event(m, EV_LOSE_TARGET, g);
    if (m == MODE_PIPE2 && !f.pipe_cam2) m = apply_event(m, EV_LOSE_TARGET, g);
    return m;
  endfunction

  task automatic log_mismatch(input string what, input mode_t exp_mode, input mode_t act_mode);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] mode mismatch (%s): expected %0d, got %0d", $realtime, what,
               exp_mode, act_mode);
    end
  endtask

  // Sample at the falling edge: values are settled and equal those of the next rising edge
  always @(negedge clk) begin
    if (rst) begin
      tracked_mode = MODE_REMOTE;
      expected_modes.delete();
    end else begin
      // retire the result transaction against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_modes.size() == 0) begin
          log_mismatch("no result expected", mode, mode);
        end else begin
          want = expected_modes.pop_front();
          if (mode !== want) log_mismatch("wrong mode", want, mode);
        end
      end
      // advance the tracked mode for the flag transaction
      if (in_valid && !in_stall) begin
        tracked_mode = tick_mode(tracked_mode, flags);
        expected_modes.push_back(tracked_mode);
      end
    end
    pending = expected_modes.size();
  end

endmodule

// File: dv/vehicle_mission_mode_controller_core_tb.sv
// Testbench top for the vehicle mission mode controller core: clock, reset,
// flag stimulus, result back-pressure, watchdog and verdict.
// Depends on vmmc_pkg, vehicle_mission_mode_controller_core and vmmc_mode_checker.
module vehicle_mission_mode_controller_core_tb;
  import vmmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 2000;
  localparam int RandomItems = 1500;

  // Flag masks in the bit order of flags_t
  localparam logic [11:0] FL_REMOTE = 12'h800;
  localparam logic [11:0] FL_UNLOCK = 12'h400;
  localparam logic [11:0] FL_STAB   = 12'h200;
  localparam logic [11:0] FL_DESC   = 12'h100;
  localparam logic [11:0] FL_ASC    = 12'h080;
  localparam logic [11:0] FL_EXPL   = 12'h040;
  localparam logic [11:0] FL_NOF    = 12'h020;
  localparam logic [11:0] FL_OBJ1   = 12'h010;
  localparam logic [11:0] FL_OBJ2   = 12'h008;
  localparam logic [11:0] FL_PIPE1  = 12'h004;
  localparam logic [11:0] FL_PIPE2  = 12'h002;
  localparam logic [11:0] FL_OBST   = 12'h001;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   out_stall = 1'b1;
  flags_t stim = '0;
  logic   in_stall;
  logic   out_valid;
  mode_t  mode;
  int     fail_total;
  int     pending_results;
  int     idle_cycles = 0;

  always #5 clk = ~clk;

  vehicle_mission_mode_controller_core DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .remote_request  (stim.remote_request),
    .unlocked        (stim.unlocked),
    .stabilize_cmd   (stim.stabilize_cmd),
    .descend_cmd     (stim.descend_cmd),
    .ascend_cmd      (stim.ascend_cmd),
    .explore_cmd     (stim.explore_cmd),
    .nofollow_cmd    (stim.nofollow_cmd),
    .obj_cam1        (stim.obj_cam1),
    .obj_cam2        (stim.obj_cam2),
    .pipe_cam1       (stim.pipe_cam1),
    .pipe_cam2       (stim.pipe_cam2),
    .obstacle_detect (stim.obstacle_detect),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .mode            (mode)
  );

  vmmc_mode_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .flags          (stim),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mode           (mode),
    .mismatch_count (fail_total),
    .pending        (pending_results)
  );

  // Offer one flag transaction and hold it until the block takes it
  task automatic offer_flags(input flags_t f);
    logic taken;
    in_valid <= 1'b1;
    stim <= f;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  // Drop valid and pause until every expected mode has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Flag stimulus: directed walk through the modes, then bursty random ticks
  initial begin
    logic [3:0] cams;
    flags_t     f;
    int         burst_left;
    int         gap;
    cams = '0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // guard closed: nothing moves
    offer_flags(flags_t'(12'h000));
    offer_flags(flags_t'(~FL_UNLOCK));
    // remote -> stay -> down -> stay -> up, obstacle while up, remote from up
    offer_flags(flags_t'(FL_UNLOCK));
    offer_flags(flags_t'(FL_UNLOCK | FL_DESC));
    offer_flags(flags_t'(FL_UNLOCK | FL_STAB));
    offer_flags(flags_t'(FL_UNLOCK | FL_ASC));
    offer_flags(flags_t'(FL_UNLOCK | FL_OBST));
    offer_flags(flags_t'(FL_UNLOCK | FL_REMOTE));
    // obstacle while staying climbs
    offer_flags(flags_t'(FL_UNLOCK | FL_OBST));
    offer_flags(flags_t'(FL_UNLOCK | FL_STAB));
    // explore, follow object 1, hand over to pipe 1, lose pipe
    offer_flags(flags_t'(FL_UNLOCK | FL_EXPL));
    offer_flags(flags_t'(FL_UNLOCK | FL_OBJ1));
    offer_flags(flags_t'(FL_UNLOCK | FL_OBJ1 | FL_PIPE1));
    offer_flags(flags_t'(FL_UNLOCK));
    // camera 2 path, obstacle while following, obstacle while exploring
    offer_flags(flags_t'(FL_UNLOCK | FL_OBJ2));
    offer_flags(flags_t'(FL_UNLOCK | FL_PIPE2));
    offer_flags(flags_t'(FL_UNLOCK | FL_PIPE2 | FL_OBST));
    offer_flags(flags_t'(FL_UNLOCK | FL_OBST));
    // several events chained in one tick
    offer_flags(flags_t'(FL_UNLOCK | FL_EXPL | FL_ASC | FL_OBJ1));
    offer_flags(flags_t'(FL_UNLOCK | FL_STAB | FL_EXPL | FL_PIPE1 | FL_OBJ1));
    offer_flags(flags_t'(FL_UNLOCK | FL_NOF | FL_PIPE1));
    // back out to remote control
    offer_flags(flags_t'(FL_UNLOCK | FL_REMOTE));
    offer_flags(flags_t'(FL_UNLOCK | FL_REMOTE));
    offer_flags(flags_t'(FL_UNLOCK | FL_REMOTE));
    offer_flags(flags_t'(12'hFFF));
    wait_drained();

    // random ticks; camera flags persist between ticks so follow modes hold
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 300 == 299) begin
        wait_drained();
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      for (int c = 0; c < 4; c++) begin
        if ($urandom_range(0, 4) == 0) cams[c] = $urandom_range(0, 1);
      end
      if ($urandom_range(0, 9) == 0) begin
        f = flags_t'($urandom_range(0, 4095));
      end else begin
        f = '0;
        f.unlocked        = ($urandom_range(0, 19) != 0);
        f.remote_request  = ($urandom_range(0, 14) == 0);
        f.stabilize_cmd   = ($urandom_range(0, 11) == 0);
        f.descend_cmd     = ($urandom_range(0, 9) == 0);
        f.ascend_cmd      = ($urandom_range(0, 9) == 0);
        f.explore_cmd     = ($urandom_range(0, 3) == 0);
        f.nofollow_cmd    = ($urandom_range(0, 11) == 0);
        f.obstacle_detect = ($urandom_range(0, 11) == 0);
        {f.obj_cam1, f.obj_cam2, f.pipe_cam1, f.pipe_cam2} = cams;
      end
      offer_flags(f);
    end

    // wind down and give the verdict
    wait_drained();
    repeat (5) @(posedge clk);
    if (fail_total == 0 && pending_results == 0) begin
      $display("vehicle_mission_mode_controller_core_tb passed");
    end else begin
      $display("vehicle_mission_mode_controller_core_tb failed");
    end
    $finish;
  end

  // Result back-pressure: a long hold first so the block fills, then mixed phases
  initial begin
    int pick;
    int len;
    while (rst) @(posedge clk);
    out_stall <= 1'b1;
    repeat ($urandom_range(40, 60)) @(posedge clk);
    forever begin
      pick = $urandom_range(0, 9);
      len = $urandom_range(5, 40);
      if (pick == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(30, 60)) @(posedge clk);
      end else if (pick < 4) begin
        out_stall <= 1'b0;
        repeat (len) @(posedge clk);
      end else begin
        repeat (len) begin
          out_stall <= ($urandom_range(0, 99) < 40);
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(negedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("vehicle_mission_mode_controller_core_tb failed");
        $finish;
      end
    end
  end

endmodule
